/* design/lwc_pkg.sv */
// Shared types, constants and the word table for the lexical word classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lwc_pkg;

   // Word length counter saturates here; the reported length saturates at 255.
   localparam int unsigned LENGTH_MAX = 255;
   localparam int unsigned LEN_CNT_W  = $clog2(LENGTH_MAX + 1);
   localparam int unsigned LEN_CALC_W = (LEN_CNT_W > 9) ? LEN_CNT_W : 9;

   localparam int unsigned TBL_ENTRIES = 17;
   localparam int unsigned TBL_IDX_W   = $clog2(TBL_ENTRIES);

   typedef enum logic [2:0] {
      CLASS_RESERVED   = 3'd0,
      CLASS_OPERATOR   = 3'd1,
      CLASS_SPECIAL    = 3'd2,
      CLASS_IDENTIFIER = 3'd3,
      CLASS_NUMBER     = 3'd4,
      CLASS_INVALID    = 3'd5
   } word_class_type;

   // text holds byte n at bits [8n+7:8n]; unused bytes are zero
   typedef struct packed {
      logic [63:0]    text;
      logic [2:0]     len;
      word_class_type cls;
   } entry_type;

   typedef struct packed {
      logic           valid;
      word_class_type cls;
      logic [7:0]     length;
   } result_type;

   function automatic entry_type tbl_entry(input logic [TBL_IDX_W-1:0] idx);
      entry_type e;
      case (idx)
         5'd0:    e = '{text: 64'h0000_003E_3E6E_6963, len: 3'd5, cls: CLASS_RESERVED};
         5'd1:    e = '{text: 64'h0000_0000_0072_6F66, len: 3'd3, cls: CLASS_RESERVED};
         5'd2:    e = '{text: 64'h0000_0000_0074_6E69, len: 3'd3, cls: CLASS_RESERVED};
         5'd3:    e = '{text: 64'h0000_3C3C_7475_6F63, len: 3'd6, cls: CLASS_RESERVED};
         5'd4:    e = '{text: 64'h0000_0000_0000_002B, len: 3'd1, cls: CLASS_OPERATOR};
         5'd5:    e = '{text: 64'h0000_0000_0000_002D, len: 3'd1, cls: CLASS_OPERATOR};
         5'd6:    e = '{text: 64'h0000_0000_0000_002A, len: 3'd1, cls: CLASS_OPERATOR};
         5'd7:    e = '{text: 64'h0000_0000_0000_002F, len: 3'd1, cls: CLASS_OPERATOR};
         5'd8:    e = '{text: 64'h0000_0000_0000_2B2B, len: 3'd2, cls: CLASS_OPERATOR};
         5'd9:    e = '{text: 64'h0000_0000_0000_2D2D, len: 3'd2, cls: CLASS_OPERATOR};
         5'd10:   e = '{text: 64'h0000_0000_0000_003C, len: 3'd1, cls: CLASS_SPECIAL};
         5'd11:   e = '{text: 64'h0000_0000_0000_003D, len: 3'd1, cls: CLASS_SPECIAL};
         5'd12:   e = '{text: 64'h0000_0000_0000_003B, len: 3'd1, cls: CLASS_SPECIAL};
         5'd13:   e = '{text: 64'h0000_0000_0000_0028, len: 3'd1, cls: CLASS_SPECIAL};
         5'd14:   e = '{text: 64'h0000_0000_0000_0029, len: 3'd1, cls: CLASS_SPECIAL};
         5'd15:   e = '{text: 64'h0000_0000_0000_3D3C, len: 3'd2, cls: CLASS_SPECIAL};
         5'd16:   e = '{text: 64'h0000_0000_0000_002C, len: 3'd1, cls: CLASS_SPECIAL};
         default: e = '{text: 64'h0, len: 3'd0, cls: CLASS_INVALID};
      endcase
      return e;
   endfunction

endpackage

/* design/lwc_scan.sv */
// Per-character word state (table candidates, identifier and number checks,
// length) and the classification of a word when it closes. Uses lwc_pkg.
`timescale 1ns / 1ps

module lwc_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         ch,
   input  logic               end_of_input,
   output lwc_pkg::result_type result
);
   import lwc_pkg::*;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_FAILED = 2'd3
   } phase_type;

   logic                   in_word_ff,  in_word_in;
   logic [TBL_ENTRIES-1:0] cand_ff,     cand_in;
   logic [2:0]             pos_ff,      pos_in;
   logic                   ident_ff,    ident_in;
   phase_type              phase_ff,    phase_in;
   logic [LEN_CNT_W-1:0]   len_ff,      len_in;

   logic                   is_space, is_digit, is_start, closing, found;
   word_class_type         cls;
   entry_type              e;
   logic [LEN_CALC_W-1:0]  len_ext;

   always_comb begin
      is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
      is_digit = (ch >= 8'h30 && ch <= 8'h39);
      is_start = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
                 (ch == 8'h5F);
      closing  = end_of_input || is_space;

      // a candidate survives only while its text still matches at this position
      for (int i = 0; i < TBL_ENTRIES; i++) begin
         e = tbl_entry(TBL_IDX_W'(i));
         cand_in[i] = cand_ff[i] && (pos_ff < e.len) &&
                      (e.text[{pos_ff, 3'b000} +: 8] == ch);
      end
      pos_in = (pos_ff == 3'd7) ? pos_ff : pos_ff + 3'd1;

      ident_in = in_word_ff ? (ident_ff && (is_start || is_digit)) : is_start;

      case (phase_ff)
         PH_START: begin
            if (is_digit)
               phase_in = PH_DIGITS;
            else if (ch == 8'h2B || ch == 8'h2D)
               phase_in = PH_SIGN;
            else
               phase_in = PH_FAILED;
         end
         PH_SIGN, PH_DIGITS: phase_in = is_digit ? PH_DIGITS : PH_FAILED;
         default: phase_in = PH_FAILED;
      endcase

      len_in = (len_ff < LEN_CNT_W'(LENGTH_MAX)) ? len_ff + LEN_CNT_W'(1) : len_ff;
      in_word_in = 1'b1;

      // lowest table index wins: scan downward, last hit stays
      found = 1'b0;
      cls   = CLASS_INVALID;
      for (int i = TBL_ENTRIES - 1; i >= 0; i--) begin
         e = tbl_entry(TBL_IDX_W'(i));
         if (cand_ff[i] && (e.len == pos_ff)) begin
            found = 1'b1;
            cls   = e.cls;
         end
      end
      if (!found) begin
         if (ident_ff)
            cls = CLASS_IDENTIFIER;
         else if (phase_ff == PH_DIGITS)
            cls = CLASS_NUMBER;
      end

      len_ext       = LEN_CALC_W'(len_ff);
      result.valid  = take && closing && in_word_ff;
      result.cls    = cls;
      result.length = (len_ext > LEN_CALC_W'(255)) ? 8'd255 : len_ext[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset || (take && closing)) begin
         in_word_ff <= 1'b0;
         cand_ff    <= '1;
         pos_ff     <= 3'd0;
         ident_ff   <= 1'b1;
         phase_ff   <= PH_START;
         len_ff     <= '0;
      end else if (take) begin
         in_word_ff <= in_word_in;
         cand_ff    <= cand_in;
         pos_ff     <= pos_in;
         ident_ff   <= ident_in;
         phase_ff   <= phase_in;
         len_ff     <= len_in;
      end
   end

endmodule

/* design/lwc_out_buf.sv */
// Two-entry result buffer: output register plus skid entry, so the input
// side keeps moving while a result waits. Uses lwc_pkg.
`timescale 1ns / 1ps

module lwc_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  lwc_pkg::result_type push,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output lwc_pkg::result_type out_data
);
   import lwc_pkg::*;

   logic       main_v_ff, skid_v_ff;
   result_type main_ff,   skid_ff;
   logic       pop;

   assign pop       = main_v_ff && out_ready;
   assign has_room  = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!main_v_ff || pop) begin
         if (skid_v_ff) begin
            main_v_ff <= 1'b1;
            main_ff   <= skid_ff;
            skid_v_ff <= 1'b0;   // no push possible while skid was full
         end else begin
            main_v_ff <= push.valid;
            main_ff   <= push;
         end
      end else if (push.valid) begin
         skid_v_ff <= 1'b1;
         skid_ff   <= push;
      end
   end

endmodule

/* design/lexical_word_classifier.sv */
// Lexical word classifier top level: word scanner and result buffer.
// Depends on lwc_pkg, lwc_scan, lwc_out_buf.
//
//   channel | ports                              | role
//   --------+------------------------------------+-------------------------
//   req     | req_valid/ready, ch, end_of_input  | one character per item
//   rsp     | rsp_valid/ready, word_class/length | one item per closed word
//
// One character is taken per cycle while req_ready is high; the word state
// updates on acceptance and a closing character's result enters the buffer.
// Synchronous reset clears the word state and empties the result buffer.
// A two-entry result buffer lets input continue while one result waits;
// req_ready drops only when both entries hold results.
`timescale 1ns / 1ps

module lexical_word_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_word_class,
   output logic [7:0] rsp_word_length
);
   import lwc_pkg::*;

   logic       take;
   result_type scan_result, out_data;

   assign take = req_valid && req_ready;

   lwc_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .ch           (req_ch),
      .end_of_input (req_end_of_input),
      .result       (scan_result)
   );

   lwc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (scan_result),
      .has_room  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_word_class  = out_data.cls;
   assign rsp_word_length = out_data.length;

endmodule

/* design/lwc_checker.sv */
// Port-level checks for the lexical word classifier, bound to the top level.
// Depends on lwc_pkg for class codes.
`timescale 1ns / 1ps

module lwc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_word_class,
   input logic [7:0] rsp_word_length
);
   import lwc_pkg::*;

   // buffer comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending right after reset");

   // input stalls only while results are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_class) &&
      $stable(rsp_word_length))
      else $error("stalled result changed");

   a_reserved_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_class == CLASS_RESERVED |->
      rsp_word_length == 8'd3 || rsp_word_length == 8'd5 || rsp_word_length == 8'd6)
      else $error("reserved word with impossible length");

   a_op_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word_class == CLASS_OPERATOR ||
      rsp_word_class == CLASS_SPECIAL) |->
      rsp_word_length == 8'd1 || rsp_word_length == 8'd2)
      else $error("operator or special with impossible length");

endmodule

bind lexical_word_classifier lwc_checker u_lwc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_word_class  (rsp_word_class),
   .rsp_word_length (rsp_word_length)
);
